FILE: sv/rvx_pkg.sv
// shared types, opcodes and alu function for the rv32im decode and execute unit
`timescale 1ns / 1ps
package rvx_pkg;

	localparam int XLEN     = 32;
	localparam int DIV_BITS = XLEN;

	// major opcodes
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_REG    = 7'h33;

	// funct7 codes
	localparam logic [6:0] F7_BASE   = 7'h00;
	localparam logic [6:0] F7_MULDIV = 7'h01;
	localparam logic [6:0] F7_ALT    = 7'h20;

	// funct3 codes
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_MUL    = 3'd0;
	localparam logic [2:0] F3_MULH   = 3'd1;
	localparam logic [2:0] F3_MULHSU = 3'd2;
	localparam logic [2:0] F3_MULHU  = 3'd3;
	localparam logic [2:0] F3_DIV    = 3'd4;
	localparam logic [2:0] F3_DIVU   = 3'd5;
	localparam logic [2:0] F3_REM    = 3'd6;
	localparam logic [2:0] F3_REMU   = 3'd7;

	localparam logic [XLEN-1:0] ALL_ONES = '1;

	// payload carried down the divider chain
	typedef struct packed {
		logic [XLEN-1:0] res;
		logic [XLEN-1:0] tgt;
		logic            tk;
		logic            misp;
		logic            ill;
		logic            is_div;
		logic            want_rem;
		logic            neg_q;
		logic            neg_r;
		logic            dzero;
		logic [XLEN-1:0] dividend;
		logic [XLEN-1:0] rem;
		logic [XLEN-1:0] quo;
		logic [XLEN-1:0] dvs;
	} cell_t;

	// base integer alu
	function automatic logic [XLEN-1:0] alu(input logic [2:0] f3, input logic alt,
		input logic [XLEN-1:0] a, input logic [XLEN-1:0] b);
		logic [4:0] sh;
		logic [XLEN-1:0] r;
		sh = b[4:0];
		case (f3)
			F3_ADD:  r = alt ? a - b : a + b;
			F3_SLL:  r = a << sh;
			F3_SLT:  r = {{(XLEN-1){1'b0}}, ($signed(a) < $signed(b))};
			F3_SLTU: r = {{(XLEN-1){1'b0}}, (a < b)};
			F3_XOR:  r = a ^ b;
			F3_SR:   r = alt ? XLEN'($signed(a) >>> sh) : a >> sh;
			F3_OR:   r = a | b;
			default: r = a & b;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/rvx_div_cell.sv
// one restoring division step cell: develops one quotient bit per stage
`timescale 1ns / 1ps
module rvx_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  rvx_pkg::cell_t in_cell,
	output logic           out_valid,
	output rvx_pkg::cell_t out_cell
);

	logic [rvx_pkg::XLEN:0] rem_sh;
	logic                   ge;
	logic [rvx_pkg::XLEN:0] diff;
	rvx_pkg::cell_t         nxt;

	// shift in next dividend bit and try subtracting the divisor
	always_comb begin
		rem_sh = {in_cell.rem, in_cell.quo[rvx_pkg::XLEN-1]};
		ge     = rem_sh >= {1'b0, in_cell.dvs};
		diff   = rem_sh - {1'b0, in_cell.dvs};
		nxt    = in_cell;
		nxt.rem = ge ? diff[rvx_pkg::XLEN-1:0] : rem_sh[rvx_pkg::XLEN-1:0];
		nxt.quo = {in_cell.quo[rvx_pkg::XLEN-2:0], ge};
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			out_cell <= nxt;
		end
	end

endmodule

FILE: sv/rv32im_decode_execute_unit.sv
// rv32im decode and execute unit: decode, alu, branch, multiply and divider chain
// path: input register, setup register, 32-cell divider chain, output register
// throughput: one instruction per cycle unless stalled; divider chain fully pipelined
// every instruction runs through the chain so results leave in order
// a stalled output holds the whole pipeline; no clearing pass after reset
// reset clears all valid flags; payload registers are not reset
`timescale 1ns / 1ps
module rv32im_decode_execute_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// instr_word[31:0], fetch_address[63:32], rs1_value[95:64], rs2_value[127:96],
	// predicted_taken[128], zero pad[135:129]
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// result[31:0], branch_target[63:32], taken[64], mispredict[65], illegal[66],
	// zero pad[71:67]
	output logic [71:0]  m_tdata
);

	localparam int XL = rvx_pkg::XLEN;
	localparam int NC = rvx_pkg::DIV_BITS;

	logic en;

	// input register
	logic          v_s1;
	logic [XL-1:0] w_s1, pc_s1, a_s1, b_s1;
	logic          pred_s1;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && s_tvalid) begin
			w_s1    <= s_tdata[31:0];
			pc_s1   <= s_tdata[63:32];
			a_s1    <= s_tdata[95:64];
			b_s1    <= s_tdata[127:96];
			pred_s1 <= s_tdata[128];
		end
	end

	// decode and execute everything but division
	logic [6:0]    op, f7;
	logic [2:0]    f3;
	logic [XL-1:0] imm_i, imm_s, imm_b, imm_j, imm_u;
	logic          ok, tk, is_mul, alt;
	logic [XL-1:0] res, tgt;
	logic          mul_a_sgn, mul_b_sgn;
	logic [2*XL+1:0] prod;
	logic          div_sgn;
	rvx_pkg::cell_t dec;

	always_comb begin
		op    = w_s1[6:0];
		f3    = w_s1[14:12];
		f7    = w_s1[31:25];
		imm_i = {{20{w_s1[31]}}, w_s1[31:20]};
		imm_s = {{20{w_s1[31]}}, w_s1[31:25], w_s1[11:7]};
		imm_b = {{20{w_s1[31]}}, w_s1[7], w_s1[30:25], w_s1[11:8], 1'b0};
		imm_j = {{12{w_s1[31]}}, w_s1[19:12], w_s1[20], w_s1[30:21], 1'b0};
		imm_u = {w_s1[31:12], 12'd0};
		ok     = 1'b1;
		tk     = 1'b0;
		is_mul = 1'b0;
		alt    = 1'b0;
		res    = '0;
		tgt    = '0;
		unique case (op)
			rvx_pkg::OP_LUI:   res = imm_u;
			rvx_pkg::OP_AUIPC: res = pc_s1 + imm_u;
			rvx_pkg::OP_JAL: begin
				res = pc_s1 + XL'(4);
				tgt = pc_s1 + imm_j;
				tk  = 1'b1;
			end
			rvx_pkg::OP_JALR: begin
				ok  = (f3 == 3'd0);
				res = pc_s1 + XL'(4);
				tgt = (a_s1 + imm_i) & ~XL'(1);
				tk  = 1'b1;
			end
			rvx_pkg::OP_BRANCH: begin
				tgt = pc_s1 + imm_b;
				unique case (f3)
					rvx_pkg::F3_BEQ:  tk = (a_s1 == b_s1);
					rvx_pkg::F3_BNE:  tk = (a_s1 != b_s1);
					rvx_pkg::F3_BLT:  tk = ($signed(a_s1) < $signed(b_s1));
					rvx_pkg::F3_BGE:  tk = !($signed(a_s1) < $signed(b_s1));
					rvx_pkg::F3_BLTU: tk = (a_s1 < b_s1);
					rvx_pkg::F3_BGEU: tk = (a_s1 >= b_s1);
					default:          ok = 1'b0;
				endcase
			end
			rvx_pkg::OP_LOAD: begin
				ok  = !(f3 == 3'd3 || f3 > 3'd5);
				res = a_s1 + imm_i;
			end
			rvx_pkg::OP_STORE: begin
				ok  = (f3 <= 3'd2);
				res = a_s1 + imm_s;
			end
			rvx_pkg::OP_IMM: begin
				if (f3 == rvx_pkg::F3_SLL && f7 != rvx_pkg::F7_BASE) begin
					ok = 1'b0;
				end
				if (f3 == rvx_pkg::F3_SR && f7 != rvx_pkg::F7_BASE && f7 != rvx_pkg::F7_ALT) begin
					ok = 1'b0;
				end
				alt = (f3 == rvx_pkg::F3_SR) && (f7 == rvx_pkg::F7_ALT);
				res = rvx_pkg::alu(f3, alt, a_s1, imm_i);
			end
			rvx_pkg::OP_REG: begin
				if (f7 == rvx_pkg::F7_MULDIV) begin
					is_mul = !f3[2];
				end else if (f7 == rvx_pkg::F7_BASE) begin
					res = rvx_pkg::alu(f3, 1'b0, a_s1, b_s1);
				end else if (f7 == rvx_pkg::F7_ALT &&
					(f3 == rvx_pkg::F3_ADD || f3 == rvx_pkg::F3_SR)) begin
					res = rvx_pkg::alu(f3, 1'b1, a_s1, b_s1);
				end else begin
					ok = 1'b0;
				end
			end
			default: ok = 1'b0;
		endcase
	end

	// multiplier on sign-extended operands
	always_comb begin
		mul_a_sgn = (f3 == rvx_pkg::F3_MULH || f3 == rvx_pkg::F3_MULHSU) && a_s1[XL-1];
		mul_b_sgn = (f3 == rvx_pkg::F3_MULH) && b_s1[XL-1];
		prod = (2*XL+2)'($signed({mul_a_sgn, a_s1}) * $signed({mul_b_sgn, b_s1}));
	end

	// stage 2 payload: final values plus divider setup
	always_comb begin
		div_sgn      = !f3[0];
		dec.res      = is_mul ? ((f3 == rvx_pkg::F3_MUL) ? prod[XL-1:0] : prod[2*XL-1:XL])
			: res;
		dec.tgt      = tgt;
		dec.tk       = tk;
		dec.misp     = pred_s1 ^ tk;
		dec.ill      = !ok;
		dec.is_div   = (op == rvx_pkg::OP_REG) && (f7 == rvx_pkg::F7_MULDIV) && f3[2];
		dec.want_rem = f3[1];
		dec.neg_q    = div_sgn && (a_s1[XL-1] ^ b_s1[XL-1]);
		dec.neg_r    = div_sgn && a_s1[XL-1];
		dec.dzero    = (b_s1 == '0);
		dec.dividend = a_s1;
		dec.rem      = '0;
		dec.quo      = (div_sgn && a_s1[XL-1]) ? -a_s1 : a_s1;
		dec.dvs      = (div_sgn && b_s1[XL-1]) ? -b_s1 : b_s1;
		if (!ok) begin
			dec.res  = '0;
			dec.tgt  = '0;
			dec.tk   = 1'b0;
			dec.misp = 1'b0;
		end
	end

	// chain of division cells
	logic           v_c [0:NC];
	rvx_pkg::cell_t c_c [0:NC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c[0] <= 1'b0;
		end else if (en) begin
			v_c[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_c[0] <= dec;
		end
	end

	for (genvar g = 0; g < NC; g++) begin : g_cell
		rvx_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_c[g]),
			.in_cell   (c_c[g]),
			.out_valid (v_c[g+1]),
			.out_cell  (c_c[g+1])
		);
	end

	// result select and output register
	rvx_pkg::cell_t fin;
	logic [XL-1:0]  fin_res;

	always_comb begin
		fin = c_c[NC];
		if (!fin.is_div || fin.ill) begin
			fin_res = fin.res;
		end else if (fin.dzero) begin
			fin_res = fin.want_rem ? fin.dividend : rvx_pkg::ALL_ONES;
		end else if (fin.want_rem) begin
			fin_res = fin.neg_r ? -fin.rem : fin.rem;
		end else begin
			fin_res = fin.neg_q ? -fin.quo : fin.quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= v_c[NC];
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_c[NC]) begin
			m_tdata <= {5'd0, fin.ill, fin.misp, fin.tk, fin.tgt, fin_res};
		end
	end

`ifndef SYNTHESIS
	a_illegal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[66] |-> m_tdata[63:0] == '0 && !m_tdata[64] && !m_tdata[65])
		else $error("illegal result carries nonzero fields");
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted transfer lost at input stage");
`endif

endmodule

FILE: test/tb_rv32im_decode_execute_unit.sv
// testbench for the rv32im decode and execute unit: random and directed instructions vs predictor
`timescale 1ns / 1ps
module tb_rv32im_decode_execute_unit;

	typedef struct packed {
		logic [31:0] instr_word;
		logic [31:0] fetch_address;
		logic [31:0] rs1_value;
		logic [31:0] rs2_value;
		logic        predicted_taken;
	} instr_t;

	typedef struct packed {
		logic [31:0] result;
		logic [31:0] branch_target;
		logic        taken;
		logic        mispredict;
		logic        illegal;
	} outcome_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 80;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;

	instr_t   pending_instrs[$];
	outcome_t expected_outcomes[$];
	int       mismatch_count;
	int       cycle_count;
	bit       stimulus_done;
	bit       long_hold;
	bit       in_fire;

	rv32im_decode_execute_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// signed less-than on raw words
	function automatic bit lt_signed(logic [31:0] a, logic [31:0] b);
		return $signed(a) < $signed(b);
	endfunction

	function automatic logic [31:0] calc_alu(logic [2:0] f3, bit alt, logic [31:0] a,
		logic [31:0] b);
		case (f3)
			rvx_pkg::F3_ADD:  return alt ? a - b : a + b;
			rvx_pkg::F3_SLL:  return a << b[4:0];
			rvx_pkg::F3_SLT:  return {31'd0, lt_signed(a, b)};
			rvx_pkg::F3_SLTU: return {31'd0, a < b};
			rvx_pkg::F3_XOR:  return a ^ b;
			rvx_pkg::F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
			rvx_pkg::F3_OR:   return a | b;
			default: return a & b;
		endcase
	endfunction

	function automatic logic [31:0] calc_muldiv(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
		logic signed [63:0] sa;
		logic signed [63:0] sb;
		logic [63:0] prod;
		sa = {{32{a[31]}}, a};
		sb = {{32{b[31]}}, b};
		case (f3)
			rvx_pkg::F3_MUL:    prod = {32'd0, a} * {32'd0, b};
			rvx_pkg::F3_MULH:   prod = sa * sb;
			rvx_pkg::F3_MULHSU: prod = sa * $signed({32'd0, b});
			rvx_pkg::F3_MULHU:  prod = {32'd0, a} * {32'd0, b};
			default:   prod = '0;
		endcase
		case (f3)
			rvx_pkg::F3_MUL: return prod[31:0];
			rvx_pkg::F3_MULH, rvx_pkg::F3_MULHSU, rvx_pkg::F3_MULHU: return prod[63:32];
			rvx_pkg::F3_DIV: begin
				if (b == 0) return rvx_pkg::ALL_ONES;
				if (a == 32'h8000_0000 && b == rvx_pkg::ALL_ONES) return a;
				return 32'($signed(a) / $signed(b));
			end
			rvx_pkg::F3_DIVU: return (b == 0) ? rvx_pkg::ALL_ONES : a / b;
			rvx_pkg::F3_REM: begin
				if (b == 0) return a;
				if (a == 32'h8000_0000 && b == rvx_pkg::ALL_ONES) return 32'd0;
				return 32'($signed(a) % $signed(b));
			end
			default: return (b == 0) ? a : a % b;
		endcase
	endfunction

	// decode and execute one instruction
	function automatic outcome_t execute_instr(instr_t it);
		outcome_t o;
		logic [31:0] w, pc, a, b, imm_i, imm_s, imm_b, imm_j;
		logic [6:0] f7;
		logic [2:0] f3;
		bit ok;
		w = it.instr_word; pc = it.fetch_address;
		a = it.rs1_value; b = it.rs2_value;
		f3 = w[14:12]; f7 = w[31:25];
		imm_i = {{20{w[31]}}, w[31:20]};
		imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
		imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
		imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
		o = '0;
		ok = 1;
		case (w[6:0])
			rvx_pkg::OP_LUI:   o.result = {w[31:12], 12'd0};
			rvx_pkg::OP_AUIPC: o.result = pc + {w[31:12], 12'd0};
			rvx_pkg::OP_JAL: begin
				o.result = pc + 4; o.branch_target = pc + imm_j; o.taken = 1;
			end
			rvx_pkg::OP_JALR: begin
				if (f3 != 0) ok = 0;
				else begin
					o.result = pc + 4; o.branch_target = (a + imm_i) & ~32'd1; o.taken = 1;
				end
			end
			rvx_pkg::OP_BRANCH: begin
				o.branch_target = pc + imm_b;
				case (f3)
					rvx_pkg::F3_BEQ:  o.taken = a == b;
					rvx_pkg::F3_BNE:  o.taken = a != b;
					rvx_pkg::F3_BLT:  o.taken = lt_signed(a, b);
					rvx_pkg::F3_BGE:  o.taken = !lt_signed(a, b);
					rvx_pkg::F3_BLTU: o.taken = a < b;
					rvx_pkg::F3_BGEU: o.taken = a >= b;
					default: ok = 0;
				endcase
			end
			rvx_pkg::OP_LOAD: begin
				if (f3 == 3 || f3 > 5) ok = 0;
				else o.result = a + imm_i;
			end
			rvx_pkg::OP_STORE: begin
				if (f3 > 2) ok = 0;
				else o.result = a + imm_s;
			end
			rvx_pkg::OP_IMM: begin
				if (f3 == rvx_pkg::F3_SLL && f7 != rvx_pkg::F7_BASE) ok = 0;
				else if (f3 == rvx_pkg::F3_SR && f7 != rvx_pkg::F7_BASE &&
					f7 != rvx_pkg::F7_ALT) ok = 0;
				else o.result = calc_alu(f3, f3 == rvx_pkg::F3_SR && f7 == rvx_pkg::F7_ALT,
					a, imm_i);
			end
			rvx_pkg::OP_REG: begin
				if (f7 == rvx_pkg::F7_MULDIV) o.result = calc_muldiv(f3, a, b);
				else if (f7 == rvx_pkg::F7_BASE) o.result = calc_alu(f3, 0, a, b);
				else if (f7 == rvx_pkg::F7_ALT &&
					(f3 == rvx_pkg::F3_ADD || f3 == rvx_pkg::F3_SR))
					o.result = calc_alu(f3, 1, a, b);
				else ok = 0;
			end
			default: ok = 0;
		endcase
		if (!ok) begin
			o = '0;
			o.illegal = 1;
		end else begin
			o.mispredict = it.predicted_taken != o.taken;
		end
		return o;
	endfunction

	// operand values biased toward edge cases
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return rvx_pkg::ALL_ONES;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'($urandom_range(0, 40));
			default: return $urandom;
		endcase
	endfunction

	// mostly legal encodings with random fields, some pure noise
	function automatic logic [31:0] pick_word();
		logic [31:0] w;
		logic [6:0] ops[9];
		ops = '{rvx_pkg::OP_LUI, rvx_pkg::OP_AUIPC, rvx_pkg::OP_JAL, rvx_pkg::OP_JALR,
			rvx_pkg::OP_BRANCH, rvx_pkg::OP_LOAD, rvx_pkg::OP_STORE, rvx_pkg::OP_IMM,
			rvx_pkg::OP_REG};
		w = $urandom;
		if ($urandom_range(0, 9) == 0) return w;
		w[6:0] = ops[$urandom_range(0, 8)];
		if (w[6:0] == rvx_pkg::OP_REG || (w[6:0] == rvx_pkg::OP_IMM && w[13:12] == 2'b01)) begin
			case ($urandom_range(0, 4))
				0, 1: w[31:25] = rvx_pkg::F7_MULDIV;
				2:    w[31:25] = rvx_pkg::F7_BASE;
				3:    w[31:25] = rvx_pkg::F7_ALT;
				default: ;
			endcase
		end
		return w;
	endfunction

	task automatic add_instr(logic [31:0] w, logic [31:0] pc, logic [31:0] a, logic [31:0] b,
		logic pred);
		instr_t it;
		it = '{w, pc, a, b, pred};
		pending_instrs.push_back(it);
	endtask

	// stimulus
	initial begin
		add_instr({20'hFFFFF, 5'd1, rvx_pkg::OP_LUI}, 32'h0, 32'h0, 32'h0, 1'b0);
		add_instr({20'h80000, 5'd1, rvx_pkg::OP_AUIPC}, rvx_pkg::ALL_ONES, 32'h0, 32'h0, 1'b1);
		add_instr(32'hFFFF_F0EF, 32'h10, 0, 0, 1'b0);
		add_instr(32'h7FFF_F0EF, rvx_pkg::ALL_ONES, 0, 0, 1'b1);
		add_instr({12'hFFF, 5'd1, 3'd0, 5'd1, rvx_pkg::OP_JALR}, 32'h100, 32'h4, 0, 1'b1);
		add_instr({12'h001, 5'd1, 3'd1, 5'd1, rvx_pkg::OP_JALR}, 32'h100, 32'h4, 0, 1'b1);
		add_instr({7'h40, 5'd2, 5'd1, rvx_pkg::F3_BEQ, 5'h1F, rvx_pkg::OP_BRANCH}, 32'h200,
			5, 5, 1'b0);
		add_instr({7'h3F, 5'd2, 5'd1, rvx_pkg::F3_BLT, 5'h1E, rvx_pkg::OP_BRANCH}, 32'h200,
			rvx_pkg::ALL_ONES, 1, 1'b1);
		add_instr({7'h00, 5'd2, 5'd1, 3'd2, 5'd0, rvx_pkg::OP_BRANCH}, 32'h200, 1, 1, 1'b0);
		add_instr({12'h800, 5'd1, 3'd5, 5'd1, rvx_pkg::OP_LOAD}, 32'h0, 32'h10, 0, 1'b0);
		add_instr({12'h800, 5'd1, 3'd3, 5'd1, rvx_pkg::OP_LOAD}, 32'h0, 32'h10, 0, 1'b0);
		add_instr({7'h7F, 5'd2, 5'd1, 3'd2, 5'h1F, rvx_pkg::OP_STORE}, 32'h0,
			rvx_pkg::ALL_ONES, 0, 1'b0);
		add_instr({7'h20, 5'd31, 5'd1, rvx_pkg::F3_SR, 5'd1, rvx_pkg::OP_IMM}, 0,
			32'h8000_0000, 0, 1'b0);
		add_instr({7'h01, 5'd3, 5'd1, rvx_pkg::F3_SLL, 5'd1, rvx_pkg::OP_IMM}, 0, 1, 0, 1'b0);
		add_instr({rvx_pkg::F7_ALT, 5'd2, 5'd1, rvx_pkg::F3_ADD, 5'd1, rvx_pkg::OP_REG}, 0,
			0, 1, 1'b0);
		add_instr({rvx_pkg::F7_ALT, 5'd2, 5'd1, rvx_pkg::F3_OR, 5'd1, rvx_pkg::OP_REG}, 0,
			0, 1, 1'b0);
		add_instr({rvx_pkg::F7_MULDIV, 5'd2, 5'd1, rvx_pkg::F3_DIV, 5'd1, rvx_pkg::OP_REG}, 0,
			7, 0, 1'b0);
		add_instr({rvx_pkg::F7_MULDIV, 5'd2, 5'd1, rvx_pkg::F3_REM, 5'd1, rvx_pkg::OP_REG}, 0,
			7, 0, 1'b0);
		add_instr({rvx_pkg::F7_MULDIV, 5'd2, 5'd1, rvx_pkg::F3_DIV, 5'd1, rvx_pkg::OP_REG}, 0,
			32'h8000_0000, rvx_pkg::ALL_ONES, 1'b0);
		add_instr({rvx_pkg::F7_MULDIV, 5'd2, 5'd1, rvx_pkg::F3_REM, 5'd1, rvx_pkg::OP_REG}, 0,
			32'h8000_0000, rvx_pkg::ALL_ONES, 1'b0);
		add_instr({rvx_pkg::F7_MULDIV, 5'd2, 5'd1, rvx_pkg::F3_MULH, 5'd1, rvx_pkg::OP_REG}, 0,
			rvx_pkg::ALL_ONES, rvx_pkg::ALL_ONES, 1'b0);
		add_instr({rvx_pkg::F7_MULDIV, 5'd2, 5'd1, rvx_pkg::F3_MULHSU, 5'd1, rvx_pkg::OP_REG},
			0, rvx_pkg::ALL_ONES, rvx_pkg::ALL_ONES, 1'b0);
		add_instr(32'h0000_000F, 0, 0, 0, 1'b1);
		add_instr(32'h0000_0073, 0, 0, 0, 1'b0);
		for (int i = 0; i < 1500; i++)
			add_instr(pick_word(), $urandom, pick_operand(), pick_operand(), 1'($urandom));
	end

	// driver: bursts with gaps, inputs change on the falling edge
	int burst_left;
	int gap_left;
	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		burst_left = 0;
		gap_left = 0;
		in_fire = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_fire) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_instrs.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, pending_instrs[0].predicted_taken,
						pending_instrs[0].rs2_value, pending_instrs[0].rs1_value,
						pending_instrs[0].fetch_address, pending_instrs[0].instr_word};
					if (burst_left > 0) burst_left <= burst_left - 1;
					else begin
						burst_left <= $urandom_range(0, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// input transfer: record the expected outcome
	always @(posedge clk) begin
		in_fire <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			expected_outcomes.push_back(execute_instr(pending_instrs.pop_front()));
			if (pending_instrs.size() == 0) stimulus_done <= 1'b1;
		end
	end

	// receiver stall pattern, with one long hold-off early in the run
	initial begin
		m_tready = 1'b0;
		long_hold = 1'b0;
	end

	always @(negedge clk) begin
		if (cycle_count == 300) long_hold <= 1'b1;
		else if (cycle_count == 450) long_hold <= 1'b0;
		if (long_hold || (cycle_count >= 300 && cycle_count < 450)) m_tready <= 1'b0;
		else if (cycle_count % 512 < 128) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	// monitor: compare each output transfer with the oldest expectation
	outcome_t seen, want;
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			seen.result        = m_tdata[31:0];
			seen.branch_target = m_tdata[63:32];
			seen.taken         = m_tdata[64];
			seen.mispredict    = m_tdata[65];
			seen.illegal       = m_tdata[66];
			if (expected_outcomes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected output transfer: %h", seen);
			end else begin
				want = expected_outcomes.pop_front();
				if (seen !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected res=%h tgt=%h tk=%b mp=%b ill=%b,",
							want.result, want.branch_target, want.taken, want.mispredict,
							want.illegal, " got res=%h tgt=%h tk=%b mp=%b ill=%b",
							seen.result, seen.branch_target, seen.taken,
							seen.mispredict, seen.illegal);
				end
			end
		end
	end

	// cycle counter with timeout
	initial begin
		cycle_count = 0;
		mismatch_count = 0;
		stimulus_done = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_rv32im_decode_execute_unit failed");
			$finish;
		end
	end

	// end of run
	initial begin
		wait (stimulus_done);
		while (expected_outcomes.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_rv32im_decode_execute_unit passed");
		else
			$display("tb_rv32im_decode_execute_unit failed");
		$finish;
	end

endmodule

FILE: sim.f
sv/rvx_pkg.sv
sv/rvx_div_cell.sv
sv/rv32im_decode_execute_unit.sv
test/tb_rv32im_decode_execute_unit.sv
